// ----- rtl/core/assert_macros.svh -----
// assertion macros for the range profiler core
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- rtl/core/frp_pkg.sv -----
// shared types, constants and codes of the function range profiler
// no dependencies
package frp_pkg;

	localparam int MAX_FUNCS = 256;
	localparam int SLOT_W    = (MAX_FUNCS > 1) ? $clog2(MAX_FUNCS) : 1;
	localparam int CNT_W     = $clog2(MAX_FUNCS + 1);

	localparam int ACTION_W = 2;
	localparam int WORD_W   = 32;
	localparam int IDX_W    = 8;
	localparam int STATUS_W = 2;
	localparam int SUM_W    = 64;

	localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_EVENT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_LOADED = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_RECENT,
		S_SCAN,
		S_UPDATE,
		S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		SOP_NONE,
		SOP_ZERO,
		SOP_CLEAR,
		SOP_READ,
		SOP_HIT,
		SOP_PEEK,
		SOP_MISS
	} stat_op_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [WORD_W-1:0]   address;
		logic [WORD_W-1:0]   range_length;
		logic [WORD_W-1:0]   cost_cycles;
		logic [IDX_W-1:0]    entry_index;
	} item_t;

	typedef struct packed {
		logic              rng_rd_en;
		logic              rng_wr_en;
		logic [SLOT_W-1:0] rng_addr;
		stat_op_t          sop;
		logic [SLOT_W-1:0] stat_addr;
	} ctrl_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                matched;
		logic [IDX_W-1:0]    func_slot;
	} head_t;

	typedef struct packed {
		logic [WORD_W-1:0] event_count;
		logic [SUM_W-1:0]  cycle_sum;
		logic [SUM_W-1:0]  grand_total;
	} stat_res_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                matched;
		logic [IDX_W-1:0]    func_slot;
		logic [WORD_W-1:0]   event_count;
		logic [SUM_W-1:0]    cycle_sum;
		logic [SUM_W-1:0]    grand_total;
	} out_word_t;

endpackage

// ----- rtl/core/frp_in_if.sv -----
// input channel of the range profiler: valid/ready plus the action word
// depends on frp_pkg
interface frp_in_if;
	logic                          valid;
	logic                          ready;
	logic [frp_pkg::ACTION_W-1:0]  action;
	logic [frp_pkg::WORD_W-1:0]    address;
	logic [frp_pkg::WORD_W-1:0]    range_length;
	logic [frp_pkg::WORD_W-1:0]    cost_cycles;
	logic [frp_pkg::IDX_W-1:0]     entry_index;

	modport source (
		output valid, action, address, range_length, cost_cycles, entry_index,
		input  ready
	);
	modport sink (
		input  valid, action, address, range_length, cost_cycles, entry_index,
		output ready
	);
endinterface

// ----- rtl/core/frp_out_if.sv -----
// result channel of the range profiler: valid/ready plus the result word
// depends on frp_pkg
interface frp_out_if;
	logic                          valid;
	logic                          ready;
	logic [frp_pkg::STATUS_W-1:0]  status;
	logic                          matched;
	logic [frp_pkg::IDX_W-1:0]     func_slot;
	logic [frp_pkg::WORD_W-1:0]    event_count;
	logic [frp_pkg::SUM_W-1:0]     cycle_sum;
	logic [frp_pkg::SUM_W-1:0]     grand_total;

	modport source (
		output valid, status, matched, func_slot, event_count, cycle_sum, grand_total,
		input  ready
	);
	modport sink (
		input  valid, status, matched, func_slot, event_count, cycle_sum, grand_total,
		output ready
	);
endinterface

// ----- rtl/core/function_range_profiler.sv -----
// top level of the function range profiler: sequencer, range table,
// statistics memory and result register; depends on frp_pkg, frp_in_if,
// frp_out_if, frp_ctrl, frp_rng, frp_stat and assert_macros.svh
//
// channel  dir  handshake      word
// item     in   valid/ready    action, address, range_length, cost_cycles, entry_index
// result   out  valid/ready    status, matched, func_slot, event_count, cycle_sum, grand_total
//
// one word at a time; load, unused action and a read of an unloaded entry pass dispatch and emit,
// a read of a loaded entry adds update; emit waits while the result register is still full
// an event passes dispatch, recent, update and emit on a recent-entry hit; on a table scan
// it steps through the loaded entries with one range-table read per cycle, then update or emit
// reset clears the miss and total counters, the loaded count and the recent entry; no clearing pass
// item is taken again while a finished result still waits in the result register
`include "assert_macros.svh"

module function_range_profiler (
	input  logic           clk,
	input  logic           arst_n,
	frp_in_if.sink         item,
	frp_out_if.source      result
);

	frp_pkg::item_t     in_word;
	frp_pkg::item_t     item_q;
	frp_pkg::head_t     head_q;
	frp_pkg::ctrl_t     cmd;
	frp_pkg::stat_res_t sres;
	frp_pkg::out_word_t out_q;
	logic               out_vld_q;
	logic               out_free;
	logic               idle;
	logic               emit;
	logic               owns;

	assign in_word.action       = item.action;
	assign in_word.address      = item.address;
	assign in_word.range_length = item.range_length;
	assign in_word.cost_cycles  = item.cost_cycles;
	assign in_word.entry_index  = item.entry_index;

	assign item.ready = idle;
	assign out_free   = !out_vld_q || result.ready;

	frp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (item.valid),
		.word     (in_word),
		.owns     (owns),
		.out_free (out_free),
		.idle     (idle),
		.emit     (emit),
		.cmd      (cmd),
		.item_q   (item_q),
		.head_q   (head_q)
	);

	frp_rng u_rng (
		.clk     (clk),
		.cmd     (cmd),
		.base    (item_q.address),
		.length  (item_q.range_length),
		.address (item_q.address),
		.owns    (owns)
	);

	frp_stat u_stat (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cost   (item_q.cost_cycles),
		.res    (sres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.status      <= head_q.status;
			out_q.matched     <= head_q.matched;
			out_q.func_slot   <= head_q.func_slot;
			out_q.event_count <= sres.event_count;
			out_q.cycle_sum   <= sres.cycle_sum;
			out_q.grand_total <= sres.grand_total;
		end
	end

	assign result.valid       = out_vld_q;
	assign result.status      = out_q.status;
	assign result.matched     = out_q.matched;
	assign result.func_slot   = out_q.func_slot;
	assign result.event_count = out_q.event_count;
	assign result.cycle_sum   = out_q.cycle_sum;
	assign result.grand_total = out_q.grand_total;

	`ASSERT_NEXT(a_one_word_at_a_time, clk, arst_n, item.valid && item.ready, !item.ready)
	`ASSERT_NEXT(a_emit_fills_result, clk, arst_n, emit, out_vld_q)
	`ASSERT_IMPLIES(a_match_is_ok, clk, arst_n, out_vld_q && out_q.matched, out_q.status == frp_pkg::ST_OK)

endmodule

// ----- rtl/core/frp_rng.sv -----
// range table memory (base, length) with registered read and ownership compare
// depends on frp_pkg
module frp_rng (
	input  logic                       clk,
	input  frp_pkg::ctrl_t             cmd,
	input  logic [frp_pkg::WORD_W-1:0] base,
	input  logic [frp_pkg::WORD_W-1:0] length,
	input  logic [frp_pkg::WORD_W-1:0] address,
	output logic                       owns
);

	typedef struct packed {
		logic [frp_pkg::WORD_W-1:0] base;
		logic [frp_pkg::WORD_W-1:0] length;
	} rng_ent_t;

	rng_ent_t                   mem [frp_pkg::MAX_FUNCS];
	rng_ent_t                   rd_q;
	logic [frp_pkg::WORD_W-1:0] range_end;

	always_ff @(posedge clk) begin
		if (cmd.rng_wr_en) begin
			mem[cmd.rng_addr] <= '{base: base, length: length};
		end
		if (cmd.rng_rd_en) begin
			rd_q <= mem[cmd.rng_addr];
		end
	end

	// end wraps at 32 bits
	assign range_end = rd_q.base + rd_q.length;
	assign owns      = (address >= rd_q.base) && (address < range_end);

endmodule

// ----- rtl/core/frp_stat.sv -----
// per-entry statistics memory with read-modify-write, miss bucket and total
// depends on frp_pkg
module frp_stat (
	input  logic                       clk,
	input  logic                       arst_n,
	input  frp_pkg::ctrl_t             cmd,
	input  logic [frp_pkg::WORD_W-1:0] cost,
	output frp_pkg::stat_res_t         res
);

	typedef struct packed {
		logic [frp_pkg::WORD_W-1:0] events;
		logic [frp_pkg::SUM_W-1:0]  cycles;
	} stat_ent_t;

	stat_ent_t                  mem [frp_pkg::MAX_FUNCS];
	stat_ent_t                  rd_q;
	stat_ent_t                  upd;
	stat_ent_t                  wr_data;
	logic                       wr_en;
	logic [frp_pkg::WORD_W-1:0] miss_ev_q;
	logic [frp_pkg::SUM_W-1:0]  miss_cyc_q;
	logic [frp_pkg::SUM_W-1:0]  total_q;
	logic [frp_pkg::WORD_W-1:0] ev_q;
	logic [frp_pkg::SUM_W-1:0]  cyc_q;
	logic [frp_pkg::SUM_W-1:0]  cost_ext;

	assign cost_ext    = frp_pkg::SUM_W'(cost);
	assign upd.events  = rd_q.events + 32'd1;
	assign upd.cycles  = rd_q.cycles + cost_ext;
	assign wr_en       = (cmd.sop == frp_pkg::SOP_CLEAR) || (cmd.sop == frp_pkg::SOP_HIT);
	assign wr_data     = (cmd.sop == frp_pkg::SOP_CLEAR) ? '0 : upd;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cmd.stat_addr] <= wr_data;
		end
		if (cmd.sop == frp_pkg::SOP_READ) begin
			rd_q <= mem[cmd.stat_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_ev_q  <= '0;
			miss_cyc_q <= '0;
			total_q    <= '0;
		end else begin
			if (cmd.sop == frp_pkg::SOP_MISS) begin
				miss_ev_q  <= miss_ev_q + 32'd1;
				miss_cyc_q <= miss_cyc_q + cost_ext;
			end
			if ((cmd.sop == frp_pkg::SOP_MISS) || (cmd.sop == frp_pkg::SOP_HIT)) begin
				total_q <= total_q + cost_ext;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.sop)
			frp_pkg::SOP_ZERO, frp_pkg::SOP_CLEAR: begin
				ev_q  <= '0;
				cyc_q <= '0;
			end
			frp_pkg::SOP_HIT: begin
				ev_q  <= upd.events;
				cyc_q <= upd.cycles;
			end
			frp_pkg::SOP_PEEK: begin
				ev_q  <= rd_q.events;
				cyc_q <= rd_q.cycles;
			end
			frp_pkg::SOP_MISS: begin
				ev_q  <= miss_ev_q + 32'd1;
				cyc_q <= miss_cyc_q + cost_ext;
			end
			default: begin
			end
		endcase
	end

	assign res.event_count = ev_q;
	assign res.cycle_sum   = cyc_q;
	assign res.grand_total = total_q;

endmodule

// ----- rtl/core/frp_ctrl.sv -----
// sequencer: captures a word, loads or reads an entry, or for an event tries the recent entry,
// scans the range table, then drives the statistics update; depends on frp_pkg
module frp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  frp_pkg::item_t        word,
	input  logic                  owns,
	input  logic                  out_free,
	output logic                  idle,
	output logic                  emit,
	output frp_pkg::ctrl_t        cmd,
	output frp_pkg::item_t        item_q,
	output frp_pkg::head_t        head_q
);

	frp_pkg::state_t              state_q;
	frp_pkg::state_t              state_d;
	logic [frp_pkg::CNT_W-1:0]    lc_q;
	logic [frp_pkg::SLOT_W-1:0]   recent_q;
	logic                         recent_vld_q;
	logic [frp_pkg::CNT_W-1:0]    ptr_q;
	logic                         chk_vld_s1;
	logic [frp_pkg::SLOT_W-1:0]   chk_idx_s1;
	logic [frp_pkg::SLOT_W-1:0]   hit_q;

	logic load_full;
	logic rd_ok;
	logic recent_ok;
	logic scan_issue;
	logic scan_hit;
	logic scan_miss;
	logic scan_start;

	always_comb begin
		load_full  = (lc_q == frp_pkg::CNT_W'(frp_pkg::MAX_FUNCS));
		rd_ok      = (32'(item_q.entry_index) < 32'(lc_q));
		recent_ok  = recent_vld_q && (frp_pkg::CNT_W'(recent_q) < lc_q);
		scan_issue = (ptr_q < lc_q);
		scan_hit   = chk_vld_s1 && owns;
		scan_miss  = !scan_issue && !chk_vld_s1;
		scan_start = ((state_q == frp_pkg::S_DISPATCH) && (item_q.action == frp_pkg::ACT_EVENT)
			&& !recent_ok) || ((state_q == frp_pkg::S_RECENT) && !owns);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			frp_pkg::S_IDLE: begin
				if (take) state_d = frp_pkg::S_DISPATCH;
			end
			frp_pkg::S_DISPATCH: begin
				case (item_q.action)
					frp_pkg::ACT_EVENT: state_d = recent_ok ? frp_pkg::S_RECENT : frp_pkg::S_SCAN;
					frp_pkg::ACT_READ:  state_d = rd_ok ? frp_pkg::S_UPDATE : frp_pkg::S_EMIT;
					default:            state_d = frp_pkg::S_EMIT;
				endcase
			end
			frp_pkg::S_RECENT: begin
				state_d = owns ? frp_pkg::S_UPDATE : frp_pkg::S_SCAN;
			end
			frp_pkg::S_SCAN: begin
				if (scan_hit) state_d = frp_pkg::S_UPDATE;
				else if (scan_miss) state_d = frp_pkg::S_EMIT;
			end
			frp_pkg::S_UPDATE: begin
				state_d = frp_pkg::S_EMIT;
			end
			frp_pkg::S_EMIT: begin
				if (out_free) state_d = frp_pkg::S_IDLE;
			end
			default: begin
				state_d = frp_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		idle          = 1'b0;
		emit          = 1'b0;
		cmd.rng_rd_en = 1'b0;
		cmd.rng_wr_en = 1'b0;
		cmd.rng_addr  = frp_pkg::SLOT_W'(lc_q);
		cmd.sop       = frp_pkg::SOP_NONE;
		cmd.stat_addr = hit_q;
		case (state_q)
			frp_pkg::S_IDLE: begin
				idle = 1'b1;
			end
			frp_pkg::S_DISPATCH: begin
				case (item_q.action)
					frp_pkg::ACT_LOAD: begin
						if (load_full) begin
							cmd.sop = frp_pkg::SOP_ZERO;
						end else begin
							cmd.rng_wr_en = 1'b1;
							cmd.sop       = frp_pkg::SOP_CLEAR;
							cmd.stat_addr = frp_pkg::SLOT_W'(lc_q);
						end
					end
					frp_pkg::ACT_EVENT: begin
						cmd.rng_rd_en = recent_ok;
						cmd.rng_addr  = recent_q;
					end
					frp_pkg::ACT_READ: begin
						cmd.sop       = rd_ok ? frp_pkg::SOP_READ : frp_pkg::SOP_ZERO;
						cmd.stat_addr = frp_pkg::SLOT_W'(item_q.entry_index);
					end
					default: begin
						cmd.sop = frp_pkg::SOP_ZERO;
					end
				endcase
			end
			frp_pkg::S_RECENT: begin
				if (owns) begin
					cmd.sop       = frp_pkg::SOP_READ;
					cmd.stat_addr = recent_q;
				end
			end
			frp_pkg::S_SCAN: begin
				cmd.rng_rd_en = scan_issue;
				cmd.rng_addr  = frp_pkg::SLOT_W'(ptr_q);
				if (scan_hit) begin
					cmd.sop       = frp_pkg::SOP_READ;
					cmd.stat_addr = chk_idx_s1;
				end else if (scan_miss) begin
					cmd.sop = frp_pkg::SOP_MISS;
				end
			end
			frp_pkg::S_UPDATE: begin
				cmd.sop = (item_q.action == frp_pkg::ACT_EVENT) ? frp_pkg::SOP_HIT
					: frp_pkg::SOP_PEEK;
			end
			frp_pkg::S_EMIT: begin
				emit = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= frp_pkg::S_IDLE;
			lc_q         <= '0;
			recent_q     <= '0;
			recent_vld_q <= 1'b0;
			ptr_q        <= '0;
			chk_vld_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == frp_pkg::S_DISPATCH) && (item_q.action == frp_pkg::ACT_LOAD)
				&& !load_full) begin
				lc_q <= lc_q + 1'b1;
			end
			if (scan_start) begin
				ptr_q      <= '0;
				chk_vld_s1 <= 1'b0;
			end else if (state_q == frp_pkg::S_SCAN) begin
				if (scan_issue) ptr_q <= ptr_q + 1'b1;
				chk_vld_s1 <= scan_issue;
			end
			if ((state_q == frp_pkg::S_SCAN) && scan_hit) begin
				recent_q     <= chk_idx_s1;
				recent_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == frp_pkg::S_IDLE) && take) begin
			item_q <= word;
		end
		if (state_q == frp_pkg::S_SCAN) begin
			chk_idx_s1 <= frp_pkg::SLOT_W'(ptr_q);
		end
		case (state_q)
			frp_pkg::S_DISPATCH: begin
				case (item_q.action)
					frp_pkg::ACT_LOAD: begin
						head_q <= load_full ? '{frp_pkg::ST_FULL, 1'b0, '0}
							: '{frp_pkg::ST_OK, 1'b0, frp_pkg::IDX_W'(lc_q)};
					end
					frp_pkg::ACT_READ: begin
						head_q <= rd_ok ? '{frp_pkg::ST_OK, 1'b1, item_q.entry_index}
							: '{frp_pkg::ST_NOT_LOADED, 1'b0, '0};
						hit_q  <= frp_pkg::SLOT_W'(item_q.entry_index);
					end
					default: begin
						head_q <= '{frp_pkg::ST_OK, 1'b0, '0};
					end
				endcase
			end
			frp_pkg::S_RECENT: begin
				if (owns) begin
					head_q <= '{frp_pkg::ST_OK, 1'b1, frp_pkg::IDX_W'(recent_q)};
					hit_q  <= recent_q;
				end
			end
			frp_pkg::S_SCAN: begin
				if (scan_hit) begin
					head_q <= '{frp_pkg::ST_OK, 1'b1, frp_pkg::IDX_W'(chk_idx_s1)};
					hit_q  <= chk_idx_s1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- tb/sv/frp_checker.sv -----
`timescale 1ns / 1ps
// checker of the function range profiler: watches both channels, keeps its own
// copy of the range table and counters, and compares every result word
// depends on frp_pkg, frp_in_if and frp_out_if
module frp_checker (
	input  logic        clk,
	input  logic        arst_n,
	frp_in_if           item,
	frp_out_if          result,
	output int unsigned failures,
	output int unsigned outstanding
);
	import frp_pkg::*;

	bit [WORD_W-1:0] base_tab [MAX_FUNCS];
	bit [WORD_W-1:0] len_tab [MAX_FUNCS];
	bit [WORD_W-1:0] hit_events [MAX_FUNCS];
	bit [SUM_W-1:0]  hit_cycles [MAX_FUNCS];
	int unsigned     n_loaded;
	int unsigned     last_slot;
	bit              last_valid;
	bit [WORD_W-1:0] miss_events;
	bit [SUM_W-1:0]  miss_cycles;
	bit [SUM_W-1:0]  total_cycles;
	out_word_t       owed_results [$];

	function automatic bit covers(input int unsigned slot, input bit [WORD_W-1:0] a);
		bit [WORD_W-1:0] lo;
		bit [WORD_W-1:0] hi;
		lo = base_tab[slot];
		hi = lo + len_tab[slot];
		return (a >= lo) && (a < hi);
	endfunction

	function automatic out_word_t charge_word(input item_t w);
		out_word_t   r;
		bit          found;
		int unsigned owner;
		int unsigned i;
		r = '0;
		found = 1'b0;
		owner = 0;
		case (w.action)
			ACT_LOAD: begin
				if (n_loaded >= MAX_FUNCS) begin
					r.status = ST_FULL;
				end else begin
					base_tab[n_loaded] = w.address;
					len_tab[n_loaded] = w.range_length;
					r.func_slot = IDX_W'(n_loaded);
					n_loaded++;
				end
			end
			ACT_EVENT: begin
				if (last_valid && last_slot < n_loaded && covers(last_slot, w.address)) begin
					found = 1'b1;
					owner = last_slot;
				end else begin
					for (i = 0; i < n_loaded; i++) begin
						if (covers(i, w.address)) begin
							found = 1'b1;
							owner = i;
							last_slot = i;
							last_valid = 1'b1;
							break;
						end
					end
				end
				total_cycles += w.cost_cycles;
				if (found) begin
					hit_events[owner]++;
					hit_cycles[owner] += w.cost_cycles;
					r.matched = 1'b1;
					r.func_slot = IDX_W'(owner);
					r.event_count = hit_events[owner];
					r.cycle_sum = hit_cycles[owner];
				end else begin
					miss_events++;
					miss_cycles += w.cost_cycles;
					r.event_count = miss_events;
					r.cycle_sum = miss_cycles;
				end
			end
			ACT_READ: begin
				if (w.entry_index < n_loaded) begin
					r.matched = 1'b1;
					r.func_slot = w.entry_index;
					r.event_count = hit_events[w.entry_index];
					r.cycle_sum = hit_cycles[w.entry_index];
				end else begin
					r.status = ST_NOT_LOADED;
				end
			end
			default: ;
		endcase
		r.grand_total = total_cycles;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		item_t     w;
		out_word_t got;
		out_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_FUNCS; i++) begin
				base_tab[i] = '0;
				len_tab[i] = '0;
				hit_events[i] = '0;
				hit_cycles[i] = '0;
			end
			n_loaded = 0;
			last_slot = 0;
			last_valid = 1'b0;
			miss_events = '0;
			miss_cycles = '0;
			total_cycles = '0;
			owed_results.delete();
			outstanding = 0;
		end else begin
			if (result.valid === 1'b1 && result.ready === 1'b1) begin
				got.status = result.status;
				got.matched = result.matched;
				got.func_slot = result.func_slot;
				got.event_count = result.event_count;
				got.cycle_sum = result.cycle_sum;
				got.grand_total = result.grand_total;
				if (owed_results.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: result word with nothing expected: st=%0d m=%0d slot=%0d ev=%0d cyc=%0d tot=%0d",
							$time, got.status, got.matched, got.func_slot,
							got.event_count, got.cycle_sum, got.grand_total);
				end else begin
					want = owed_results.pop_front();
					if (got.status !== want.status || got.matched !== want.matched ||
							got.func_slot !== want.func_slot ||
							got.event_count !== want.event_count ||
							got.cycle_sum !== want.cycle_sum ||
							got.grand_total !== want.grand_total) begin
						failures++;
						if (failures <= 10) begin
							$display("%0t: mismatch exp st=%0d m=%0d slot=%0d ev=%0d cyc=%0d tot=%0d",
								$time, want.status, want.matched, want.func_slot,
								want.event_count, want.cycle_sum, want.grand_total);
							$display("%0t:          got st=%0d m=%0d slot=%0d ev=%0d cyc=%0d tot=%0d",
								$time, got.status, got.matched, got.func_slot,
								got.event_count, got.cycle_sum, got.grand_total);
						end
					end
				end
			end
			if (item.valid === 1'b1 && item.ready === 1'b1) begin
				w.action = item.action;
				w.address = item.address;
				w.range_length = item.range_length;
				w.cost_cycles = item.cost_cycles;
				w.entry_index = item.entry_index;
				owed_results.insert(owed_results.size(), charge_word(w));
			end
			outstanding = owed_results.size();
		end
	end

endmodule

// ----- tb/sv/tb_function_range_profiler.sv -----
`timescale 1ns / 1ps
// top of the function range profiler testbench: clock, reset, directed and random
// words under several idling phases, and the verdict from frp_checker
// depends on frp_pkg, frp_in_if, frp_out_if, frp_checker and the profiler rtl
module tb_function_range_profiler;
	import frp_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
	localparam int PHASE_ITEMS = 250;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	int unsigned     idle_pct = 0;
	int unsigned     stall_pct = 0;
	int unsigned     failures;
	int unsigned     outstanding;
	bit [WORD_W-1:0] tab_base [$];
	bit [WORD_W-1:0] tab_len [$];
	bit [WORD_W-1:0] last_addr = '0;

	frp_in_if  item_ch ();
	frp_out_if result_ch ();

	function_range_profiler u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch.sink),
		.result (result_ch.source)
	);

	frp_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic offer_word(input item_t w);
		while ($urandom_range(99) < idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= w.action;
		item_ch.address <= w.address;
		item_ch.range_length <= w.range_length;
		item_ch.cost_cycles <= w.cost_cycles;
		item_ch.entry_index <= w.entry_index;
		@(posedge clk);
		while (item_ch.ready !== 1'b1) @(posedge clk);
		if (w.action == ACT_LOAD && tab_base.size() < MAX_FUNCS) begin
			tab_base.insert(tab_base.size(), w.address);
			tab_len.insert(tab_len.size(), w.range_length);
		end
	endtask

	task automatic offer_fields(input logic [ACTION_W-1:0] act, input bit [WORD_W-1:0] addr,
			input bit [WORD_W-1:0] len, input bit [WORD_W-1:0] cost, input bit [IDX_W-1:0] idx);
		item_t w;
		w.action = act;
		w.address = addr;
		w.range_length = len;
		w.cost_cycles = cost;
		w.entry_index = idx;
		offer_word(w);
	endtask

	function automatic item_t make_random_word();
		item_t           w;
		int unsigned     r;
		int unsigned     k;
		bit [WORD_W-1:0] b;
		bit [WORD_W-1:0] l;
		w.action = ACT_NONE;
		w.address = $urandom;
		w.range_length = $urandom;
		w.cost_cycles = $urandom;
		w.entry_index = IDX_W'($urandom_range(255));
		r = $urandom_range(99);
		if (r < 33) begin
			w.action = ACT_LOAD;
			if ($urandom_range(99) < 60)
				w.address = $urandom_range(32'h000F_FFFF);
			r = $urandom_range(99);
			if (r < 15)
				w.range_length = '0;
			else if (r < 60)
				w.range_length = $urandom_range(4096, 1);
			else if (r < 80)
				w.range_length = $urandom_range(32'h000F_FFFF, 1);
		end else if (r < 78) begin
			w.action = ACT_EVENT;
			r = $urandom_range(99);
			if (tab_base.size() > 0 && r < 75) begin
				k = $urandom_range(tab_base.size() - 1);
				b = tab_base[k];
				l = tab_len[k];
				case ($urandom_range(4))
					0: w.address = b;
					1: w.address = b + l - 1;
					2: w.address = b + l;
					3: w.address = b - 1;
					default: w.address = (l == 0) ? b : b + ($urandom % l);
				endcase
			end else if (r < 88) begin
				w.address = last_addr;
			end
			r = $urandom_range(99);
			if (r < 10)
				w.cost_cycles = '0;
			else if (r < 20)
				w.cost_cycles = '1;
			last_addr = w.address;
		end else if (r < 95) begin
			w.action = ACT_READ;
			if (tab_base.size() > 0 && $urandom_range(99) < 70)
				w.entry_index = IDX_W'($urandom_range(tab_base.size() - 1));
		end
		return w;
	endfunction

	initial begin : stimulus
		int unsigned ph;
		int unsigned n;
		item_ch.valid = 1'b0;
		item_ch.action = ACT_LOAD;
		item_ch.address = '0;
		item_ch.range_length = '0;
		item_ch.cost_cycles = '0;
		item_ch.entry_index = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: reads not loaded, event goes to the miss bucket
		offer_fields(ACT_READ, '0, '0, '0, 8'd0);
		offer_fields(ACT_READ, '1, '1, '1, 8'd255);
		offer_fields(ACT_EVENT, '0, '0, '1, '0);
		offer_fields(ACT_NONE, '1, '1, '1, 8'd255);
		// overlapping ranges, empty ranges and wrapping ends
		offer_fields(ACT_LOAD, 32'h0000_1000, 32'h0000_0100, '0, '0);
		offer_fields(ACT_LOAD, 32'h0000_1080, 32'h0000_0100, '0, '0);
		offer_fields(ACT_LOAD, 32'hFFFF_FFF0, 32'h0000_0010, '0, '0);
		offer_fields(ACT_LOAD, '0, '0, '0, '0);
		offer_fields(ACT_LOAD, 32'h0000_2000, '1, '0, '0);
		offer_fields(ACT_LOAD, 32'hFFFF_FF00, 32'h0000_00FF, '0, '0);
		offer_fields(ACT_EVENT, 32'h0000_1000, '0, '0, '0);
		offer_fields(ACT_EVENT, 32'h0000_10FF, '0, '1, '0);
		offer_fields(ACT_EVENT, 32'h0000_1100, '0, 32'd5, '0);
		// recent entry wins over a lower index
		offer_fields(ACT_EVENT, 32'h0000_1080, '0, 32'd7, '0);
		offer_fields(ACT_EVENT, '1, '0, 32'd3, '0);
		offer_fields(ACT_EVENT, 32'hFFFF_FFFE, '0, '1, '0);
		offer_fields(ACT_EVENT, '0, '0, 32'd11, '0);
		offer_fields(ACT_EVENT, 32'hFFFF_FFF5, '0, 32'd13, '0);
		offer_fields(ACT_READ, '0, '0, '0, 8'd0);
		offer_fields(ACT_READ, '0, '0, '0, 8'd1);
		offer_fields(ACT_READ, '0, '0, '0, 8'd5);
		offer_fields(ACT_READ, '0, '0, '0, 8'd6);
		offer_fields(ACT_NONE, '0, '0, '0, '0);

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 67;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 67;
				end
				default: begin
					idle_pct = 35;
					stall_pct = 35;
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++)
				offer_word(make_random_word());
		end
		item_ch.valid <= 1'b0;

		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (300) @(posedge clk);
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- function_range_profiler.f -----
+incdir+rtl/core
rtl/core/frp_pkg.sv
rtl/core/frp_in_if.sv
rtl/core/frp_out_if.sv
rtl/core/frp_rng.sv
rtl/core/frp_stat.sv
rtl/core/frp_ctrl.sv
rtl/core/function_range_profiler.sv
tb/sv/frp_checker.sv
tb/sv/tb_function_range_profiler.sv
